// ----- rtl/ptsc_pkg.sv -----
`timescale 1ns / 1ps

package ptsc_pkg;

  // Field and register widths.
  localparam int PIXEL_W    = 16;
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Shift-add multiplier: multiplicand, multiplier and product widths.
  localparam int MUL_A_W   = 24;
  localparam int MUL_B_W   = 40;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Restoring divider: dividend and divisor widths.
  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 3'd6;

  // Arithmetic constants.
  localparam logic [DIV_D_W-1:0] FILTER_DIVISOR = 32'd100;
  localparam logic [DIV_D_W-1:0] MS_DIVISOR     = 32'd1000;
  localparam logic [DIV_N_W-1:0] SLEW_SAT       = 64'd4194304000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_RAW_DIV,
    ST_FILT_SUM,
    ST_FILT_DIV,
    ST_INT_MUL,
    ST_INT_DIV,
    ST_CAND,
    ST_GP_MUL,
    ST_GD_MUL,
    ST_GI_MUL,
    ST_SAT,
    ST_DESIRED,
    ST_DELTA,
    ST_SLEW_MUL,
    ST_SLEW_DIV,
    ST_SLEW_CMP,
    ST_COMMIT,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/ptsc_if.sv -----
`timescale 1ns / 1ps

interface ptsc_sample_if import ptsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      target_seen;
  logic signed [PIXEL_W-1:0] pixel_error;
  logic [TIME_W-1:0]         time_ms;

  modport source(output valid, target_seen, pixel_error, time_ms, input ready);
  modport sink(input valid, target_seen, pixel_error, time_ms, output ready);
endinterface

interface ptsc_command_if import ptsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_command;

  modport source(output valid, speed_command, input ready);
  modport sink(input valid, speed_command, output ready);
endinterface

// ----- rtl/ptsc_mul.sv -----
`timescale 1ns / 1ps

module ptsc_mul
  import ptsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   areg;
  logic [MUL_P_W-1:0]   acc;
  logic [MUL_A_W:0]     sum;

  // One multiplier bit per cycle: add the multiplicand into the upper half, then shift right.
  always_comb begin
    sum = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (acc[0] ? {1'b0, areg} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MUL_B_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      acc  <= {{MUL_A_W{1'b0}}, b};
    end else if (busy) begin
      acc <= {sum, acc[MUL_B_W-1:1]};
    end
  end

  assign prod = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");

endmodule

// ----- rtl/ptsc_div.sv -----
`timescale 1ns / 1ps

module ptsc_div
  import ptsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               done,
  output logic [DIV_N_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   dreg;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_N_W-1:0]   nreg;
  logic [DIV_D_W:0]     rs;
  logic [DIV_D_W:0]     dif;
  logic                 ge;

  // Restoring division, one quotient bit per cycle; quotient bits shift in where the dividend leaves.
  always_comb begin
    rs  = {rem, nreg[DIV_N_W-1]};
    dif = rs - {1'b0, dreg};
    ge  = !dif[DIV_D_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_N_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= den;
      rem  <= '0;
      nreg <= num;
    end else if (busy) begin
      rem  <= ge ? dif[DIV_D_W-1:0] : rs[DIV_D_W-1:0];
      nreg <= {nreg[DIV_N_W-2:0], ge};
    end
  end

  assign quot = nreg;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

// ----- rtl/pid_tracking_speed_controller_top.sv -----
`timescale 1ns / 1ps

// Tracking speed controller: one signed speed command for each request.
// Channels: "sample" carries target_seen, pixel_error and time_ms; "command"
// returns speed_command. Both use valid/ready; a request is taken on a clock
// edge with valid and ready high. Registers are written through write_en,
// write_index and write_data, one register per cycle; the user must write them
// only while the block is idle, and the block itself does not enforce it.
// Work is done by a sequencer around one shift-add multiplier and one restoring
// divider. A request with no target or a zero limit goes straight to the output
// register, a deadzone request skips to the slew step, and a full PID request
// runs up to six products and four quotients in sequence. Only one request is
// in work at a time; sample.ready is high while the sequencer is idle, so the
// next request can be taken in the cycle after the previous result is
// registered. The result sits in an output register until taken, so a stalled
// receiver holds back only the next finished request: the next request is
// accepted meanwhile, but its result waits in ST_OUT, with sample.ready low,
// until the earlier one is taken. Reset (synchronous, active high) zeroes the
// configuration registers, the controller history and the output valid.
module pid_tracking_speed_controller_top
  import ptsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_en,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  ptsc_sample_if.sink           sample,
  ptsc_command_if.source        command
);

  // Configuration.
  logic [14:0] deadzone;
  logic [23:0] gain_p, gain_i, gain_d, accel_limit;
  logic [30:0] integral_bound;
  logic [19:0] speed_limit;

  // Controller history.
  logic signed [31:0] integ;
  logic signed [39:0] deriv;
  logic signed [15:0] last_err;
  logic [31:0]        last_time;
  logic signed [20:0] last_cmd;
  logic               hist;

  // Per-request work registers.
  state_t             state, state_next;
  logic               seen;
  logic signed [15:0] err;
  logic [31:0]        t_now;
  logic [31:0]        elapsed;
  logic               have_dt;
  logic               frozen;
  logic               launched;
  logic signed [39:0] raw;
  logic signed [47:0] fsum;
  logic [63:0]        acc_mag;
  logic signed [48:0] inc;
  logic signed [31:0] cand;
  logic signed [63:0] p_term;
  logic signed [63:0] pd_sum;
  logic signed [63:0] ctrl;
  logic signed [44:0] desired;
  logic signed [46:0] delta;
  logic signed [57:0] d1000;
  logic [23:0]        q_m;
  logic signed [20:0] cmd;
  logic               res_valid;
  logic signed [20:0] res_cmd;

  // Arithmetic units.
  logic               mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic [DIV_N_W-1:0] div_num, div_quot;
  logic [DIV_D_W-1:0] div_den;

  // Combinational helpers.
  logic [31:0]        elapsed_c;
  logic [15:0]        err_mag;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic [63:0]        raw_num;
  logic               in_dead;
  logic               cfg_off;
  logic [47:0]        fsum_mag;
  logic [39:0]        deriv_mag;
  logic [31:0]        cand_mag, integ_mag;
  logic               gi_neg;
  logic signed [49:0] cand_sum;
  logic signed [49:0] bound_x;
  logic signed [63:0] maxq;
  logic signed [63:0] nctrl;
  logic               sat_match;
  logic signed [57:0] slew_lim;
  logic signed [24:0] step;
  logic signed [24:0] cmd_sum;
  logic signed [47:0] raw_x, der_x;
  logic signed [57:0] delta_x;

  function automatic logic signed [22:0] trunc24(input logic signed [46:0] x);
    logic [46:0] mag;
    logic [22:0] q;
    mag = x[46] ? (~x + 47'd1) : x;
    q   = mag[46:24];
    return x[46] ? $signed(~q + 23'd1) : $signed(q);
  endfunction

  always_comb begin
    elapsed_c = t_now - last_time;
    err_mag   = err[15] ? (~err + 16'd1) : err;
    diff      = {err[15], err} - {last_err[15], last_err};
    diff_mag  = diff[16] ? (~diff + 17'd1) : diff;
    // 256000 = 2^18 - 2^12 - 2^11
    raw_num   = ({47'd0, diff_mag} << 18) - ({47'd0, diff_mag} << 12)
              - ({47'd0, diff_mag} << 11);
    in_dead   = err_mag <= {1'b0, deadzone};
    cfg_off   = !seen || (speed_limit == '0) || (accel_limit == '0);
    raw_x     = 48'(raw);
    der_x     = 48'(deriv);
    fsum_mag  = fsum[47] ? (~fsum + 48'd1) : fsum;
    deriv_mag = deriv[39] ? (~deriv + 40'd1) : deriv;
    cand_mag  = cand[31] ? (~cand + 32'd1) : cand;
    integ_mag = integ[31] ? (~integ + 32'd1) : integ;
    gi_neg    = frozen ? integ[31] : cand[31];
    cand_sum  = 50'(integ) + 50'(inc);
    bound_x   = $signed({19'd0, integral_bound});
    maxq      = $signed({20'd0, speed_limit, 24'd0});
    nctrl     = -ctrl;
    // Saturated in the direction of the error: the integral is held.
    sat_match = ((ctrl > maxq) || (ctrl < -maxq)) &&
                ((ctrl > 64'sd0 && !err[15] && err != '0) || (ctrl < 64'sd0 && err[15]));
    delta_x   = 58'(delta);
    slew_lim  = $signed({2'd0, acc_mag[31:0], 24'd0});
    if (d1000 > slew_lim) begin
      step = $signed({1'b0, q_m});
    end else if (d1000 < -slew_lim) begin
      step = -$signed({1'b0, q_m});
    end else begin
      step = 25'(trunc24(delta));
    end
    cmd_sum = 25'(last_cmd) + step;
  end

  // Operands of the shared units, chosen by the step in progress.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = MS_DIVISOR;
    case (state)
      ST_INT_MUL: begin
        mul_a = MUL_A_W'(err_mag);
        mul_b = MUL_B_W'(elapsed);
      end
      ST_GP_MUL: begin
        mul_a = gain_p;
        mul_b = MUL_B_W'(err_mag);
      end
      ST_GD_MUL: begin
        mul_a = gain_d;
        mul_b = deriv_mag;
      end
      ST_GI_MUL: begin
        mul_a = gain_i;
        mul_b = MUL_B_W'(frozen ? integ_mag : cand_mag);
      end
      ST_SLEW_MUL: begin
        mul_a = accel_limit;
        mul_b = MUL_B_W'(elapsed);
      end
      ST_RAW_DIV: begin
        div_num = raw_num;
        div_den = elapsed;
      end
      ST_FILT_DIV: begin
        div_num = DIV_N_W'(fsum_mag);
        div_den = FILTER_DIVISOR;
      end
      ST_INT_DIV: begin
        div_num = {acc_mag[47:0], 16'd0};
      end
      ST_SLEW_DIV: begin
        div_num = acc_mag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample.valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (cfg_off) state_next = ST_OUT;
        else if (in_dead) state_next = ST_DELTA;
        else state_next = ST_RAW_DIV;
      end
      ST_RAW_DIV: begin
        if (!have_dt) state_next = ST_FILT_SUM;
        else if (!launched) div_start = 1'b1;
        else if (div_done) state_next = ST_FILT_SUM;
      end
      ST_FILT_SUM: state_next = ST_FILT_DIV;
      ST_FILT_DIV: begin
        if (!hist) state_next = ST_INT_MUL;
        else if (!launched) div_start = 1'b1;
        else if (div_done) state_next = ST_INT_MUL;
      end
      ST_INT_MUL: begin
        if (!have_dt) state_next = ST_CAND;
        else if (!launched) mul_start = 1'b1;
        else if (mul_done) begin
          state_next = (mul_prod[63:40] != '0) ? ST_CAND : ST_INT_DIV;
        end
      end
      ST_INT_DIV: begin
        if (!launched) div_start = 1'b1;
        else if (div_done) state_next = ST_CAND;
      end
      ST_CAND: state_next = ST_GP_MUL;
      ST_GP_MUL: begin
        if (!launched) mul_start = 1'b1;
        else if (mul_done) state_next = ST_GD_MUL;
      end
      ST_GD_MUL: begin
        if (!launched) mul_start = 1'b1;
        else if (mul_done) state_next = ST_GI_MUL;
      end
      ST_GI_MUL: begin
        if (!launched) mul_start = 1'b1;
        else if (mul_done) state_next = frozen ? ST_DESIRED : ST_SAT;
      end
      ST_SAT: state_next = sat_match ? ST_GI_MUL : ST_DESIRED;
      ST_DESIRED: state_next = ST_DELTA;
      ST_DELTA: state_next = ST_SLEW_MUL;
      ST_SLEW_MUL: begin
        if (!have_dt) state_next = ST_COMMIT;
        else if (!launched) mul_start = 1'b1;
        else if (mul_done) state_next = ST_SLEW_DIV;
      end
      ST_SLEW_DIV: begin
        if (acc_mag >= SLEW_SAT) state_next = ST_COMMIT;
        else if (!launched) div_start = 1'b1;
        else if (div_done) state_next = ST_SLEW_CMP;
      end
      ST_SLEW_CMP: state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_OUT;
      ST_OUT: begin
        if (!res_valid || command.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone       <= '0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_bound <= '0;
      speed_limit    <= '0;
      accel_limit    <= '0;
    end else if (write_en) begin
      case (write_index)
        REG_DEADZONE: deadzone       <= write_data[14:0];
        REG_GAIN_P:   gain_p         <= write_data[23:0];
        REG_GAIN_I:   gain_i         <= write_data[23:0];
        REG_GAIN_D:   gain_d         <= write_data[23:0];
        REG_BOUND:    integral_bound <= write_data[30:0];
        REG_SPEED:    speed_limit    <= write_data[19:0];
        REG_ACCEL:    accel_limit    <= write_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else if (mul_start || div_start) begin
      launched <= 1'b1;
    end else if (mul_done || div_done) begin
      launched <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      deriv     <= '0;
      last_err  <= '0;
      last_time <= '0;
      last_cmd  <= '0;
      hist      <= 1'b0;
      res_valid <= 1'b0;
      frozen    <= 1'b0;
      have_dt   <= 1'b0;
    end else begin
      // In ST_OUT the output register is reloaded below instead.
      if (res_valid && command.ready && state != ST_OUT) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            seen  <= sample.target_seen;
            err   <= sample.pixel_error;
            t_now <= sample.time_ms;
          end
        end
        ST_PREP: begin
          elapsed <= elapsed_c;
          have_dt <= hist && (elapsed_c != '0);
          frozen  <= 1'b0;
          if (cfg_off) begin
            integ     <= '0;
            deriv     <= '0;
            last_err  <= '0;
            last_time <= '0;
            last_cmd  <= '0;
            hist      <= 1'b0;
            cmd       <= '0;
          end else if (in_dead) begin
            integ   <= '0;
            deriv   <= '0;
            desired <= '0;
          end
        end
        ST_RAW_DIV: begin
          if (!have_dt) begin
            raw <= '0;
          end else if (div_done) begin
            raw <= diff[16] ? -$signed(div_quot[39:0]) : $signed(div_quot[39:0]);
          end
        end
        ST_FILT_SUM: begin
          // 35 * raw + 65 * previous filter output
          fsum <= (raw_x <<< 5) + (raw_x <<< 1) + raw_x + (der_x <<< 6) + der_x;
        end
        ST_FILT_DIV: begin
          if (!hist) begin
            deriv <= '0;
          end else if (div_done) begin
            deriv <= fsum[47] ? -$signed(div_quot[39:0]) : $signed(div_quot[39:0]);
          end
        end
        ST_INT_MUL: begin
          if (!have_dt) begin
            inc <= '0;
          end else if (mul_done) begin
            acc_mag <= mul_prod;
            // A step of 2^40 pixel-ms or more saturates the increment.
            inc <= err[15] ? -49'sh800000000000 : 49'sh800000000000;
          end
        end
        ST_INT_DIV: begin
          if (div_done) begin
            inc <= err[15] ? -$signed(div_quot[48:0]) : $signed(div_quot[48:0]);
          end
        end
        ST_CAND: begin
          if (cand_sum > bound_x) cand <= bound_x[31:0];
          else if (cand_sum < -bound_x) cand <= -bound_x[31:0];
          else cand <= cand_sum[31:0];
        end
        ST_GP_MUL: begin
          if (mul_done) begin
            p_term <= err[15] ? -$signed(mul_prod << 8) : $signed(mul_prod << 8);
          end
        end
        ST_GD_MUL: begin
          if (mul_done) begin
            pd_sum <= p_term + (deriv[39] ? -$signed(mul_prod) : $signed(mul_prod));
          end
        end
        ST_GI_MUL: begin
          if (mul_done) begin
            ctrl <= pd_sum + (gi_neg ? -$signed({8'd0, mul_prod[63:8]})
                                     : $signed({8'd0, mul_prod[63:8]}));
          end
        end
        ST_SAT: begin
          if (sat_match) frozen <= 1'b1;
          else integ <= cand;
        end
        ST_DESIRED: begin
          if (nctrl > maxq) desired <= maxq[44:0];
          else if (nctrl < -maxq) desired <= -maxq[44:0];
          else desired <= nctrl[44:0];
        end
        ST_DELTA: begin
          delta <= 47'(desired) - (47'(last_cmd) <<< 24);
        end
        ST_SLEW_MUL: begin
          if (!have_dt) begin
            cmd <= 21'(trunc24(47'(desired)));
          end else if (mul_done) begin
            acc_mag <= mul_prod;
            d1000   <= (delta_x <<< 10) - (delta_x <<< 4) - (delta_x <<< 3);
          end
        end
        ST_SLEW_DIV: begin
          if (acc_mag >= SLEW_SAT) begin
            cmd <= 21'(25'(last_cmd) + 25'(trunc24(delta)));
          end else if (div_done) begin
            q_m <= div_quot[23:0];
          end
        end
        ST_SLEW_CMP: begin
          cmd <= cmd_sum[20:0];
        end
        ST_COMMIT: begin
          last_err  <= err;
          last_time <= t_now;
          last_cmd  <= cmd;
          hist      <= 1'b1;
        end
        ST_OUT: begin
          if (!res_valid || command.ready) begin
            res_valid <= 1'b1;
            res_cmd   <= cmd;
          end
        end
        default: ;
      endcase
    end
  end

  assign sample.ready          = (state == ST_IDLE);
  assign command.valid         = res_valid;
  assign command.speed_command = res_cmd;

  ptsc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ptsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  a_one_unit: assert property (@(posedge clk) disable iff (rst) !(mul_start && div_start))
    else $error("multiplier and divider launched together");

  a_commit_hist: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT) |=> hist)
    else $error("history not marked after commit");

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == ST_PREP))
    else $error("accepted request did not start processing");

endmodule
